[src/jsu_pkg.sv]
// Shared types, constants and helpers for the JSON string unescaper.
// Used by the front end, the unit queue and the back end.
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] LIMIT_RESET = 16'd16380;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;
   localparam logic [1:0] MODE_DONE   = 2'd3;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   // One decoded unit: up to three output bytes plus end status.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] cnt;
      logic       ends;
      logic       trunc;
   } unit_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h37);
      end
      return n;
   endfunction

endpackage

[src/jsu_front.sv]
// Front end: takes raw bytes, runs the escape/hex state machine and the
// output byte budget, and emits one decoded unit per productive byte.
// Depends on jsu_pkg.
module jsu_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                in_byte,
   input  logic                      first,
   input  logic                      cfg_we,
   input  logic [15:0]               cfg_limit,
   output logic                      push,
   output jsu_pkg::unit_type         unit
);

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  hex_ff, hex_in;
   logic [15:0] code_ff, code_in;
   logic [15:0] bo_ff, bo_in;
   logic [15:0] limit_ff, limit_in;

   logic [1:0]  mode_eff;
   logic [1:0]  hex_eff;
   logic [15:0] code_eff;
   logic [15:0] bo_eff;
   logic [15:0] code_shift;
   logic [15:0] cp;
   logic        emit_code;
   logic        emit_one;
   logic [7:0]  one_byte;
   logic        ends;
   logic        trunc;
   logic [16:0] sum;
   logic [15:0] bo_new;

   always_comb begin
      mode_eff   = first ? jsu_pkg::MODE_NORMAL : mode_ff;
      hex_eff    = first ? 2'd0 : hex_ff;
      code_eff   = first ? 16'd0 : code_ff;
      bo_eff     = first ? 16'd0 : bo_ff;
      code_shift = {code_eff[11:0], jsu_pkg::hex_nibble(in_byte)};

      mode_in   = mode_eff;
      hex_in    = hex_eff;
      code_in   = code_eff;
      emit_code = 1'b0;
      emit_one  = 1'b0;
      one_byte  = in_byte;
      cp        = code_shift;
      ends      = 1'b0;
      trunc     = 1'b0;

      unique case (mode_eff)
         jsu_pkg::MODE_NORMAL: begin
            if (bo_eff >= limit_ff) begin
               ends  = 1'b1;
               trunc = 1'b1;
            end else if (in_byte == jsu_pkg::CHAR_NUL || in_byte == jsu_pkg::CHAR_QUOTE) begin
               ends = 1'b1;
            end else if (in_byte == jsu_pkg::CHAR_BACKSLASH) begin
               mode_in = jsu_pkg::MODE_ESCAPE;
            end else begin
               emit_one = 1'b1;
            end
         end
         jsu_pkg::MODE_ESCAPE: begin
            mode_in = jsu_pkg::MODE_NORMAL;
            priority if (in_byte == jsu_pkg::CHAR_NUL) begin
               ends = 1'b1;
            end else if (in_byte == jsu_pkg::CHAR_N) begin
               emit_one = 1'b1;
               one_byte = jsu_pkg::CHAR_LF;
            end else if (in_byte == jsu_pkg::CHAR_T) begin
               emit_one = 1'b1;
               one_byte = jsu_pkg::CHAR_TAB;
            end else if (in_byte == jsu_pkg::CHAR_R) begin
               mode_in = jsu_pkg::MODE_NORMAL;
            end else if (in_byte == jsu_pkg::CHAR_U) begin
               mode_in = jsu_pkg::MODE_HEX;
               hex_in  = 2'd0;
               code_in = 16'd0;
            end else begin
               emit_one = 1'b1;
            end
         end
         jsu_pkg::MODE_HEX: begin
            if (in_byte == jsu_pkg::CHAR_NUL) begin
               emit_code = 1'b1;
               cp        = code_eff;
               ends      = 1'b1;
            end else begin
               code_in = code_shift;
               hex_in  = hex_eff + 2'd1;
               if (hex_eff == 2'd3) begin
                  emit_code = 1'b1;
                  mode_in   = jsu_pkg::MODE_NORMAL;
                  hex_in    = 2'd0;
               end
            end
         end
         default: begin
            mode_in = jsu_pkg::MODE_DONE;
         end
      endcase

      unit.byte0 = one_byte;
      unit.byte1 = 8'd0;
      unit.byte2 = 8'd0;
      unit.cnt   = emit_one ? 2'd1 : 2'd0;
      if (emit_code) begin
         if (cp < 16'h0080) begin
            unit.byte0 = cp[7:0];
            unit.cnt   = 2'd1;
         end else if (cp < 16'h0800) begin
            unit.byte0 = 8'hC0 | {3'd0, cp[10:6]};
            unit.byte1 = 8'h80 | {2'd0, cp[5:0]};
            unit.cnt   = 2'd2;
         end else begin
            unit.byte0 = 8'hE0 | {4'd0, cp[15:12]};
            unit.byte1 = 8'h80 | {2'd0, cp[11:6]};
            unit.byte2 = 8'h80 | {2'd0, cp[5:0]};
            unit.cnt   = 2'd3;
         end
      end

      sum    = {1'b0, bo_eff} + {15'd0, unit.cnt};
      bo_new = sum[16] ? 16'hFFFF : sum[15:0];
      bo_in  = bo_new;

      if (!ends && unit.cnt != 2'd0 && bo_new >= limit_ff) begin
         ends  = 1'b1;
         trunc = 1'b1;
      end
      if (ends) begin
         mode_in = jsu_pkg::MODE_DONE;
      end
      unit.ends  = ends;
      unit.trunc = trunc;

      push     = accept && mode_eff != jsu_pkg::MODE_DONE && (unit.cnt != 2'd0 || ends);
      limit_in = cfg_we ? cfg_limit : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jsu_pkg::MODE_NORMAL;
         hex_ff   <= 2'd0;
         code_ff  <= 16'd0;
         bo_ff    <= 16'd0;
         limit_ff <= jsu_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
         if (accept) begin
            mode_ff <= mode_in;
            hex_ff  <= hex_in;
            code_ff <= code_in;
            bo_ff   <= bo_in;
         end
      end
   end

endmodule

[src/jsu_queue.sv]
// Short FIFO of decoded units between the front end and the back end.
// Depends on jsu_pkg.
module jsu_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  jsu_pkg::unit_type           push_unit,
   input  logic                        pop,
   output jsu_pkg::unit_type           head,
   output jsu_pkg::queue_status_type   status
);

   jsu_pkg::unit_type mem [jsu_pkg::QUEUE_DEPTH];

   logic [jsu_pkg::QUEUE_AW-1:0] wr_ff, wr_in;
   logic [jsu_pkg::QUEUE_AW-1:0] rd_ff, rd_in;
   logic [jsu_pkg::QUEUE_CW-1:0] cnt_ff, cnt_in;
   logic                         do_push;
   logic                         do_pop;

   always_comb begin
      status.full  = cnt_ff == jsu_pkg::QUEUE_CW'(jsu_pkg::QUEUE_DEPTH);
      status.empty = cnt_ff == '0;
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_in        = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in        = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in       = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
      head = mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_unit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[src/jsu_back.sv]
// Back end: walks the bytes of the head unit, one result word per cycle while
// rsp_stall does not hold the output, into a registered output stage.
// Depends on jsu_pkg.
module jsu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  jsu_pkg::unit_type           head,
   input  jsu_pkg::queue_status_type   status,
   output logic                        pop,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_done_res,
   output logic                        rsp_truncated,
   output logic                        rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in;
   logic       done_ff, done_in;
   logic       trunc_ff, trunc_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_last;

   always_comb begin
      load    = !valid_ff || !rsp_stall;
      is_last = head.cnt == 2'd0 || idx_ff == head.cnt - 2'd1;
      pop     = load && !status.empty && is_last;

      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      bv_in    = bv_ff;
      done_in  = done_ff;
      trunc_in = trunc_ff;
      last_in  = last_ff;

      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            unique case (idx_ff)
               2'd0:    byte_in = head.cnt == 2'd0 ? 8'd0 : head.byte0;
               2'd1:    byte_in = head.byte1;
               default: byte_in = head.byte2;
            endcase
            bv_in    = head.cnt != 2'd0;
            last_in  = is_last;
            done_in  = is_last && head.ends;
            trunc_in = is_last && head.trunc;
            idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      bv_ff    <= bv_in;
      done_ff  <= done_in;
      trunc_ff <= trunc_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_truncated  = trunc_ff;
   assign rsp_last       = last_ff;

endmodule

[src/json_string_unescape.sv]
// JSON string unescaper top level: front end, unit queue and back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Feed the bytes after the opening quote, with req_first set on the first
// one. One raw byte is accepted every cycle while the four-entry unit queue
// has room; each byte yields zero or one unit of up to three output bytes.
// Results leave the back end at one word per cycle while rsp_stall is low, so
// a \u escape that encodes to three UTF-8 bytes holds the back end while its
// three bytes leave; it took six input bytes to build, so the queue absorbs it
// and input runs at one byte per cycle unless rsp_stall backs the queue up.
// A result word is registered first in the unit queue and then in the back
// end's output stage. The limit register is taken on any csr_valid cycle
// (csr_ready is always high) and should change only while the block is idle.
module json_string_unescape (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_done_res,
   output logic        rsp_truncated,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_out_limit
);

   jsu_pkg::unit_type         front_unit;
   jsu_pkg::unit_type         head;
   jsu_pkg::queue_status_type status;
   logic                      push;
   logic                      pop;
   logic                      accept;

   assign csr_ready = 1'b1;
   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .first     (req_first),
      .cfg_we    (csr_valid && csr_ready),
      .cfg_limit (csr_out_limit),
      .push      (push),
      .unit      (front_unit)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_unit (front_unit),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (status),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_truncated  (rsp_truncated),
      .rsp_last       (rsp_last)
   );

endmodule

[src/jsu_checker.sv]
// Port-level checks for the JSON string unescaper, bound to its top level.
// Depends on json_string_unescape.
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_done_res,
   input logic       rsp_truncated,
   input logic       rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result word changed");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_done_res && rsp_last && rsp_out_byte == 8'd0)
      else $error("byteless word without end of string");

   a_trunc_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_done_res)
      else $error("truncated without done");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_last)
      else $error("done on a word that is not last");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_done_res   (rsp_done_res),
   .rsp_truncated  (rsp_truncated),
   .rsp_last       (rsp_last)
);
